@@ rtl/ascii_unsigned_integer_parser_defines.svh @@
// Assertion macros shared by the parser RTL.
// Needs signals named clock and reset in the including module.
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_DEFINES_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define AUP_ASSERT_IMPLY(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define AUP_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/aup_pkg.sv @@
// Shared types, character codes and helpers for the ASCII integer parser.
// No dependencies.
package aup_pkg;

   localparam int CHAR_W      = 8;
   localparam int RADIX_W     = 6;
   localparam int DIGIT_W     = 6;
   localparam int VALUE_PORT_W = 64;
   localparam int OFFSET_W    = 9;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

   // radix codes
   localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

   // digit value of a character that is no digit at all
   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIX_ADDR = 3'd0;

   typedef enum logic [4:0] {
      PH_SPACE  = 5'b00001,
      PH_SIGNED = 5'b00010,
      PH_ZERO   = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_SOME = 2'd1,
      ST_OVER = 2'd2
   } status_type;

   // classified character as it sits in the queue
   typedef struct packed {
      logic               last;
      logic               is_space;
      logic               is_minus;
      logic               is_plus;
      logic               is_zero;
      logic               is_x;
      logic [DIGIT_W-1:0] digit;
   } class_type;

   // value of a digit character in bases up to 36
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] ch);
      logic [DIGIT_W-1:0] d;
      d = DIGIT_NONE;
      if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d = DIGIT_W'(ch - CHAR_ZERO);
      end else if (ch inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
         d = DIGIT_W'(ch - CHAR_UC_A + 8'd10);
      end else if (ch inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
         d = DIGIT_W'(ch - CHAR_LC_A + 8'd10);
      end
      return d;
   endfunction

endpackage

@@ rtl/aup_front.sv @@
// Front end: takes request characters and classifies them for the queue.
// Depends on aup_pkg.
module aup_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [aup_pkg::CHAR_W-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  logic                        q_full,
   output logic                        q_push,
   output aup_pkg::class_type          q_entry
);

   // request handshake against queue space
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // character classes
   always_comb begin
      q_entry.last     = req_tlast;
      q_entry.is_space = (req_tdata == aup_pkg::CHAR_SPACE) ||
                         (req_tdata inside {[aup_pkg::CHAR_TAB:aup_pkg::CHAR_CR]});
      q_entry.is_minus = (req_tdata == aup_pkg::CHAR_MINUS);
      q_entry.is_plus  = (req_tdata == aup_pkg::CHAR_PLUS);
      q_entry.is_zero  = (req_tdata == aup_pkg::CHAR_ZERO);
      q_entry.is_x     = (req_tdata == aup_pkg::CHAR_LC_X) ||
                         (req_tdata == aup_pkg::CHAR_UC_X);
      q_entry.digit    = aup_pkg::digit_of(req_tdata);
   end

endmodule

@@ rtl/aup_queue.sv @@
// Short queue of classified characters between front and back end.
// Depends on aup_pkg.
module aup_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aup_pkg::class_type entry_in,
   input  logic               pop,
   output logic               valid,
   output logic               full,
   output aup_pkg::class_type entry
);

   localparam int PTR_W = $clog2(aup_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(aup_pkg::QUEUE_DEPTH + 1);

   aup_pkg::class_type entries_ff [aup_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign valid = (count_ff != '0);
   assign full  = (count_ff == CNT_W'(aup_pkg::QUEUE_DEPTH));
   assign entry = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ rtl/aup_back.sv @@
// Back end: parse state machine, digit multiply-add, finish and output stages.
// Depends on aup_pkg.
module aup_back #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_CHARS   = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [aup_pkg::RADIX_W-1:0]       radix,
   input  logic                              q_valid,
   input  aup_pkg::class_type                q_entry,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [aup_pkg::VALUE_PORT_W-1:0]  rsp_value,
   output logic                              rsp_error,
   output logic [aup_pkg::OFFSET_W-1:0]      rsp_offset
);

   localparam int CNT_W  = $clog2(MAX_CHARS + 1);
   localparam int PROD_W = VALUE_WIDTH + aup_pkg::RADIX_W;

   // parse state
   aup_pkg::phase_type              phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]          acc_ff, acc_in;
   aup_pkg::status_type             status_ff, status_in;
   logic [aup_pkg::RADIX_W-1:0]     wrad_ff, wrad_in;
   logic [CNT_W-1:0]                seen_ff, seen_in;
   logic [CNT_W-1:0]                dend_ff, dend_in;

   // finish stage
   logic                            fin_valid_ff, fin_valid_in;
   logic [VALUE_WIDTH-1:0]          fin_acc_ff;
   logic                            fin_neg_ff;
   logic                            fin_over_ff;
   logic                            fin_some_ff;
   logic [CNT_W-1:0]                fin_dend_ff;

   // output stage
   logic                            out_valid_ff, out_valid_in;
   logic [aup_pkg::VALUE_PORT_W-1:0] out_value_ff, out_value_in;
   logic                            out_error_ff, out_error_in;
   logic [aup_pkg::OFFSET_W-1:0]    out_offset_ff, out_offset_in;

   logic                            out_free;
   logic                            fin_free;
   logic                            in_range;
   logic [aup_pkg::RADIX_W-1:0]     base_cur;
   logic                            go_sign;
   logic                            take;
   logic [aup_pkg::RADIX_W-1:0]     take_b;
   logic                            digit_ok;
   logic [PROD_W-1:0]               prod;
   logic [VALUE_WIDTH-1:0]          mag;
   logic [CNT_W+aup_pkg::OFFSET_W-1:0] dend_ext;

   // stage handshakes
   assign out_free = !out_valid_ff || rsp_ready;
   assign fin_free = !fin_valid_ff || out_free;
   assign q_pop    = q_valid && (!q_entry.last || fin_free);

   // radix is latched on the first character of a string
   assign in_range = (seen_ff < CNT_W'(MAX_CHARS));
   assign base_cur = (seen_ff == '0) ? radix : wrad_ff;

   // one multiply-add per digit
   assign prod = PROD_W'(acc_ff) * PROD_W'(take_b) + PROD_W'(q_entry.digit);

   // next parse state for the character at the head of the queue
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      wrad_in   = base_cur;
      seen_in   = seen_ff;
      dend_in   = dend_ff;
      go_sign   = 1'b0;
      take      = 1'b0;
      take_b    = base_cur;
      digit_ok  = 1'b0;

      if (in_range) begin
         seen_in = seen_ff + CNT_W'(1);
         case (phase_ff)
            aup_pkg::PH_SPACE: begin
               if (q_entry.is_minus) begin
                  neg_in   = 1'b1;
                  phase_in = aup_pkg::PH_SIGNED;
               end else if (q_entry.is_plus) begin
                  phase_in = aup_pkg::PH_SIGNED;
               end else if (!q_entry.is_space) begin
                  go_sign = 1'b1;
               end
            end
            aup_pkg::PH_SIGNED: begin
               go_sign = 1'b1;
            end
            aup_pkg::PH_ZERO: begin
               if (q_entry.is_x) begin
                  wrad_in  = aup_pkg::RADIX_HEX;
                  phase_in = aup_pkg::PH_DIGITS;
               end else begin
                  take    = 1'b1;
                  take_b  = (base_cur == aup_pkg::RADIX_AUTO) ? aup_pkg::RADIX_OCT : base_cur;
                  wrad_in = take_b;
               end
            end
            aup_pkg::PH_DIGITS: begin
               take = 1'b1;
            end
            default: begin
            end
         endcase

         // first character after optional sign: a leading zero may open a prefix
         if (go_sign) begin
            if (((base_cur == aup_pkg::RADIX_AUTO) || (base_cur == aup_pkg::RADIX_HEX)) &&
                q_entry.is_zero) begin
               acc_in    = '0;
               status_in = aup_pkg::ST_SOME;
               dend_in   = seen_ff + CNT_W'(1);
               phase_in  = aup_pkg::PH_ZERO;
            end else begin
               take    = 1'b1;
               take_b  = (base_cur == aup_pkg::RADIX_AUTO) ? aup_pkg::RADIX_DEC : base_cur;
               wrad_in = take_b;
            end
         end

         // digit accumulation with saturation
         if (take) begin
            digit_ok = (take_b >= aup_pkg::RADIX_MIN) && (take_b <= aup_pkg::RADIX_MAX) &&
                       (q_entry.digit < take_b);
            if (!digit_ok) begin
               phase_in = aup_pkg::PH_DONE;
            end else begin
               phase_in = aup_pkg::PH_DIGITS;
               dend_in  = seen_ff + CNT_W'(1);
               if (status_ff != aup_pkg::ST_OVER) begin
                  if (prod[PROD_W-1:VALUE_WIDTH] != '0) begin
                     status_in = aup_pkg::ST_OVER;
                  end else begin
                     acc_in    = prod[VALUE_WIDTH-1:0];
                     status_in = aup_pkg::ST_SOME;
                  end
               end
            end
         end
      end
   end

   // parse state registers; the last character hands off and restarts
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= aup_pkg::PH_SPACE;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         status_ff <= aup_pkg::ST_NONE;
         wrad_ff   <= aup_pkg::RADIX_AUTO;
         seen_ff   <= '0;
         dend_ff   <= '0;
      end else if (q_pop) begin
         if (q_entry.last) begin
            phase_ff  <= aup_pkg::PH_SPACE;
            neg_ff    <= 1'b0;
            acc_ff    <= '0;
            status_ff <= aup_pkg::ST_NONE;
            wrad_ff   <= wrad_in;
            seen_ff   <= '0;
            dend_ff   <= '0;
         end else begin
            phase_ff  <= phase_in;
            neg_ff    <= neg_in;
            acc_ff    <= acc_in;
            status_ff <= status_in;
            wrad_ff   <= wrad_in;
            seen_ff   <= seen_in;
            dend_ff   <= dend_in;
         end
      end
   end

   // finish stage: capture the closing state
   assign fin_valid_in = fin_free ? (q_pop && q_entry.last) : fin_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_free && q_pop && q_entry.last) begin
         fin_acc_ff  <= acc_in;
         fin_neg_ff  <= neg_in;
         fin_over_ff <= (status_in == aup_pkg::ST_OVER);
         fin_some_ff <= (status_in != aup_pkg::ST_NONE);
         fin_dend_ff <= dend_in;
      end
   end

   // output stage: saturate or negate, trim the offset
   always_comb begin
      if (fin_over_ff) begin
         mag = '1;
      end else if (fin_neg_ff) begin
         mag = '0 - fin_acc_ff;
      end else begin
         mag = fin_acc_ff;
      end
      dend_ext      = (CNT_W + aup_pkg::OFFSET_W)'(fin_dend_ff);
      out_value_in  = aup_pkg::VALUE_PORT_W'(mag);
      out_error_in  = fin_over_ff;
      out_offset_in = fin_some_ff ? dend_ext[aup_pkg::OFFSET_W-1:0] : '0;
      out_valid_in  = out_free ? fin_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && fin_valid_ff) begin
         out_value_ff  <= out_value_in;
         out_error_ff  <= out_error_in;
         out_offset_ff <= out_offset_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_error  = out_error_ff;
   assign rsp_offset = out_offset_ff;

endmodule

@@ rtl/ascii_unsigned_integer_parser.sv @@
// Top level of the streaming ASCII to unsigned integer parser.
// Depends on aup_pkg, aup_front, aup_queue, aup_back and the defines header.
//
// Channel   Direction  Handshake          Contents
// req       in         tvalid/tready      tdata = ch, tlast = end_of_string
// rsp       out        tvalid/tready      tdata = value, end_offset; tuser = range_error
// csr       in         APB psel/penable   radix register at byte address 0
//
// One character per cycle sustained while rsp is not stalled; the digit multiply-add
// in the back end handles one queued character each cycle, but a last character waits while the finish stage is held.
// After its last character is taken, a result passes through the queue, the finish
// stage and the output register before it shows on rsp.
// Reset is synchronous and clears the queue, parse state and radix (to 0).
// A two-entry queue and the finish/output registers absorb rsp stalls.
`include "ascii_unsigned_integer_parser_defines.svh"

module ascii_unsigned_integer_parser #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_CHARS   = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] ch
   input  logic                                req_tlast,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [79:0]                         rsp_tdata,   // [63:0] value, [72:64] end_offset
   output logic [0:0]                          rsp_tuser,   // [0] range_error
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aup_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [aup_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [aup_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [aup_pkg::RADIX_W-1:0]      radix_ff, radix_in;
   logic                             radix_sel;
   logic                             q_push;
   logic                             q_pop;
   logic                             q_valid;
   logic                             q_full;
   aup_pkg::class_type               q_wr_entry;
   aup_pkg::class_type               q_rd_entry;
   logic [aup_pkg::VALUE_PORT_W-1:0] rsp_value;
   logic                             rsp_error;
   logic [aup_pkg::OFFSET_W-1:0]     rsp_offset;
   logic                             rsp_sat_ok;

   // register port
   assign csr_pready = 1'b1;
   assign radix_sel  = (csr_paddr[aup_pkg::CSR_ADDR_W-1:2] ==
                        aup_pkg::CSR_RADIX_ADDR[aup_pkg::CSR_ADDR_W-1:2]);
   assign radix_in   = (csr_psel && csr_penable && csr_pwrite && radix_sel) ?
                       csr_pwdata[aup_pkg::RADIX_W-1:0] : radix_ff;
   assign csr_prdata = radix_sel ? aup_pkg::CSR_DATA_W'(radix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= aup_pkg::RADIX_AUTO;
      end else begin
         radix_ff <= radix_in;
      end
   end

   aup_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_wr_entry)
   );

   aup_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_wr_entry),
      .pop      (q_pop),
      .valid    (q_valid),
      .full     (q_full),
      .entry    (q_rd_entry)
   );

   aup_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_CHARS   (MAX_CHARS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .radix      (radix_ff),
      .q_valid    (q_valid),
      .q_entry    (q_rd_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_error  (rsp_error),
      .rsp_offset (rsp_offset)
   );

   // result packing
   assign rsp_tdata = {7'b0, rsp_offset, rsp_value};
   assign rsp_tuser = rsp_error;

   // a range error always comes with an all-ones value
   assign rsp_sat_ok = !rsp_error || (&rsp_value[VALUE_WIDTH-1:0]);

   // checks
   `AUP_ASSERT_IMPLY(a_pop_has_entry, q_pop, q_valid, "queue popped while empty")
   `AUP_ASSERT_NEXT(a_request_queued, req_tvalid && req_tready, q_valid, "request lost")
   `AUP_ASSERT_IMPLY(a_range_saturates, rsp_tvalid, rsp_sat_ok, "range error unsaturated")

endmodule
